@@ hdl/lpt_pkg.sv @@
`timescale 1ns / 1ps

package lpt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int ADDR_W        = 32;
    localparam int PLEN_W        = 6;
    localparam int ROUTE_W       = 8;

    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [ADDR_W-1:0]  address;
        logic [PLEN_W-1:0]  prefix_len;
        logic [ROUTE_W-1:0] route_id;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [ROUTE_W-1:0] match_id;
        logic               status;
    } rsp_t;

    // One stored route.
    typedef struct packed {
        logic [ADDR_W-1:0]  network;
        logic [PLEN_W-1:0]  prefix;
        logic [ROUTE_W-1:0] route;
    } entry_t;

    // Insert command broadcast to every cell.
    typedef struct packed {
        logic   en;
        entry_t ent;
    } ins_t;

    // What a cell hands to its right-hand neighbor for an insert shift.
    typedef struct packed {
        logic   ge;
        logic   valid;
        entry_t ent;
    } link_t;

    // Lookup token that walks down the row of cells.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [ROUTE_W-1:0] id;
    } token_t;

    // Network mask for a prefix length already limited to ADDR_W.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        prefix_mask = ~({ADDR_W{1'b1}} >> plen);
    endfunction

endpackage

@@ hdl/lpt_cell.sv @@
`timescale 1ns / 1ps

module lpt_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  lpt_pkg::ins_t  ins,
    input  logic [lpt_pkg::ADDR_W-1:0] dest,
    input  lpt_pkg::link_t link_in,
    output lpt_pkg::link_t link_out,
    input  lpt_pkg::token_t tok_in,
    output lpt_pkg::token_t tok_out
);

    logic            valid_reg;
    logic            valid_next;
    lpt_pkg::entry_t ent_reg;
    lpt_pkg::entry_t ent_next;
    lpt_pkg::token_t tok_reg;
    lpt_pkg::token_t tok_next;
    logic            ge;
    logic            match;

    // The new route belongs at or before this cell unless this cell holds a longer prefix.
    assign ge    = !(valid_reg && (ins.ent.prefix < ent_reg.prefix));
    assign match = valid_reg
                   && ((dest & lpt_pkg::prefix_mask(ent_reg.prefix)) == ent_reg.network);

    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (ins.en && ge)
        begin
            if (link_in.ge)
            begin
                valid_next = link_in.valid;
                ent_next   = link_in.ent;
            end
            else
            begin
                valid_next = 1'b1;
                ent_next   = ins.ent;
            end
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && match)
        begin
            tok_next.hit = 1'b1;
            tok_next.id  = ent_reg.route;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign link_out.ge    = ge;
    assign link_out.valid = valid_reg;
    assign link_out.ent   = ent_reg;
    assign tok_out        = tok_reg;

endmodule

@@ hdl/ipv4_longest_prefix_table.sv @@
`timescale 1ns / 1ps

// IPv4 longest-prefix route table built as a row of TABLE_DEPTH cells, each
// holding one route, kept in order of falling prefix length with the newest
// route first among equal prefixes. An insert request masks the address to
// its prefix (lengths above 32 count as 32); every cell decides in parallel
// whether it keeps its route, takes its left neighbor's route, or takes the
// new one. When the table is full the insert is refused with status 1 and
// nothing changes. A lookup request sends a token down the row, one cell per
// cycle, and the first matching cell stamps its route id into it; once the
// token leaves the last cell its result is loaded into the output register,
// and no request is accepted while a lookup token is in the row. Inserts
// can be taken one per cycle while no response is stalled, but a lookup
// must leave the row before the next request is taken. Responses wait in
// that output register, so a stalled response holds off any new request
// until it is taken.
module ipv4_longest_prefix_table
#(
    parameter int TABLE_DEPTH = lpt_pkg::DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lpt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lpt_pkg::rsp_t rsp
);

    lpt_pkg::link_t  links [TABLE_DEPTH+1];
    lpt_pkg::token_t toks  [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] vld;

    logic                        busy_reg;
    logic                        busy_next;
    logic                        start_reg;
    logic [lpt_pkg::ADDR_W-1:0]  dest_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    lpt_pkg::rsp_t               out_reg;
    lpt_pkg::rsp_t               out_next;
    logic                        out_load;

    logic                        accept;
    logic                        is_insert;
    logic                        full;
    logic [lpt_pkg::PLEN_W-1:0]  plen_sat;
    lpt_pkg::ins_t               ins;
    lpt_pkg::token_t             last_tok;

    assign full      = vld[TABLE_DEPTH-1];
    assign req_stall = busy_reg || (out_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign is_insert = (req.cmd == lpt_pkg::CMD_INSERT);

    assign plen_sat = (req.prefix_len > lpt_pkg::PLEN_MAX) ? lpt_pkg::PLEN_MAX
                                                           : req.prefix_len;

    assign ins.en          = accept && is_insert && !full;
    assign ins.ent.network = req.address & lpt_pkg::prefix_mask(plen_sat);
    assign ins.ent.prefix  = plen_sat;
    assign ins.ent.route   = req.route_id;

    // The leftmost cell has no neighbor, so a new route stops there at the latest.
    assign links[0] = '{ge: 1'b0, valid: 1'b0, ent: '0};
    assign toks[0]  = '{valid: start_reg, hit: 1'b0, id: '0};

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            lpt_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ins      (ins),
                .dest     (dest_reg),
                .link_in  (links[gi]),
                .link_out (links[gi+1]),
                .tok_in   (toks[gi]),
                .tok_out  (toks[gi+1])
            );
            assign vld[gi] = links[gi+1].valid;
        end
    endgenerate

    assign last_tok = toks[TABLE_DEPTH];

    // A lookup keeps the block busy until its token leaves the last cell.
    always_comb
    begin
        busy_next = busy_reg;
        if (last_tok.valid)
        begin
            busy_next = 1'b0;
        end
        else if (accept && !is_insert)
        begin
            busy_next = 1'b1;
        end
    end

    // Insert responses and lookup results never compete for the output
    // register, since no request is taken while a lookup is in the row.
    always_comb
    begin
        out_load = 1'b0;
        out_next = out_reg;
        if (accept && is_insert)
        begin
            out_load          = 1'b1;
            out_next.hit      = 1'b0;
            out_next.match_id = '0;
            out_next.status   = full ? lpt_pkg::STATUS_FULL : lpt_pkg::STATUS_OK;
        end
        else if (last_tok.valid)
        begin
            out_load          = 1'b1;
            out_next.hit      = last_tok.hit;
            out_next.match_id = last_tok.id;
            out_next.status   = lpt_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            start_reg     <= accept && !is_insert;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept && !is_insert)
        begin
            dest_reg <= req.address;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTH
    // Valid routes always fill the row from the left without gaps.
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld + TABLE_DEPTH'(1)) & vld) == '0)
        else $error("route table has a gap in its valid entries");

    // An accepted insert into a table with room adds exactly one route.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_insert && !full)
        |=> ($countones(vld) == $past($countones(vld)) + 1))
        else $error("insert did not add exactly one route");

    // A lookup token can only leave the row while the block is busy.
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        last_tok.valid |-> busy_reg)
        else $error("lookup token without a lookup in flight");

    // A response without a hit carries no route id.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.hit) |-> (rsp.match_id == '0))
        else $error("miss response carries a route id");
`endif

endmodule

@@ tb/sv/route_table_checker.sv @@
`timescale 1ns / 1ps

module route_table_checker
    import lpt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_stall,
    input  req_t  req,
    input  logic  rsp_valid,
    input  logic  rsp_stall,
    input  rsp_t  rsp,
    output int    mismatches,
    output int    pending,
    output int    hits,
    output int    refusals
);

    // Own copy of the route table: entries 0 .. tbl_used-1 are live.
    logic [ADDR_W-1:0]  tbl_net [TABLE_DEPTH];
    logic [PLEN_W-1:0]  tbl_len [TABLE_DEPTH];
    logic [ROUTE_W-1:0] tbl_id  [TABLE_DEPTH];
    int                 tbl_used = 0;

    rsp_t route_answers [$];
    rsp_t want;

    function automatic logic [ADDR_W-1:0] network_mask(input logic [PLEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int b = 0; b < ADDR_W; b++)
            if (b < len)
                m[ADDR_W-1-b] = 1'b1;
        return m;
    endfunction

    // Applies one request to the table copy and returns the answer it must get.
    function automatic rsp_t apply_route_request(input req_t r);
        rsp_t              ans;
        logic [PLEN_W-1:0] len;
        int                pos;
        int                i;
        bit                found;
        ans          = '0;
        ans.status   = STATUS_OK;
        if (r.cmd == CMD_INSERT)
        begin
            len = (r.prefix_len > PLEN_MAX) ? PLEN_MAX : r.prefix_len;
            if (tbl_used >= TABLE_DEPTH)
            begin
                ans.status = STATUS_FULL;
                refusals++;
            end
            else
            begin
                // New route goes ahead of every route with an equal or shorter prefix.
                pos = 0;
                while (pos < tbl_used && len < tbl_len[pos])
                    pos++;
                for (i = tbl_used; i > pos; i--)
                begin
                    tbl_net[i] = tbl_net[i-1];
                    tbl_len[i] = tbl_len[i-1];
                    tbl_id[i]  = tbl_id[i-1];
                end
                tbl_net[pos] = r.address & network_mask(len);
                tbl_len[pos] = len;
                tbl_id[pos]  = r.route_id;
                tbl_used++;
            end
        end
        else
        begin
            found = 1'b0;
            for (i = 0; i < tbl_used && !found; i++)
            begin
                if ((r.address & network_mask(tbl_len[i])) == tbl_net[i])
                begin
                    found        = 1'b1;
                    ans.hit      = 1'b1;
                    ans.match_id = tbl_id[i];
                    hits++;
                end
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_used = 0;
            route_answers.delete();
            pending    = 0;
            mismatches = 0;
            hits       = 0;
            refusals   = 0;
        end
        else
        begin
            // Responses are checked before this edge's request is predicted,
            // since a request cannot be answered in the cycle it is taken.
            if (rsp_valid && !rsp_stall)
            begin
                if (route_answers.size() == 0)
                begin
                    $display("%0t: response with none outstanding: hit %0d id %0d status %0d",
                             $time, rsp.hit, rsp.match_id, rsp.status);
                    mismatches++;
                end
                else
                begin
                    want = route_answers.pop_front();
                    if (rsp.hit !== want.hit || rsp.match_id !== want.match_id
                        || rsp.status !== want.status)
                    begin
                        $display({"%0t: expected hit %0d id %0d status %0d, ",
                                  "got hit %0d id %0d status %0d"},
                                 $time, want.hit, want.match_id, want.status,
                                 rsp.hit, rsp.match_id, rsp.status);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
                route_answers.push_back(apply_route_request(req));
            pending = route_answers.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import lpt_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    // A full table-length lookup walks every cell; the long response
    // hold-off is the longest quiet stretch a correct run can show, so the
    // watchdog limit sits well above both.
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 510;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int mismatches;
    int pending;
    int hits;
    int refusals;

    // Sender and receiver idle rates, in percent of cycles.
    int send_idle_pct = 0;
    int rsp_idle_pct  = 0;

    // The top asks for a long hold-off by bumping hold_asks; the stall
    // process notices the change and counts the stretch out on its own.
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;

    int quiet_cycles = 0;
    int inserts_sent = 0;
    int lookups_sent = 0;

    // Routes the table actually holds, used to aim lookups at them.
    logic [ADDR_W-1:0] route_addr [$];
    int                route_len  [$];

    always #4 clk = ~clk;

    ipv4_longest_prefix_table #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    route_table_checker #(
        .TABLE_DEPTH (DEPTH)
    ) checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending),
        .hits       (hits),
        .refusals   (refusals)
    );

    // Response side back-pressure: either a long hold-off in progress or a
    // random stall at the current rate.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_done)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= hold_asks;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
        end
    end

    // Watchdog: a run that stops moving requests and responses has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d responses outstanding",
                         $time, QUIET_LIMIT, pending);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic req_t route_request(input logic cmd, input logic [ADDR_W-1:0] address,
                                           input logic [PLEN_W-1:0] plen,
                                           input logic [ROUTE_W-1:0] id);
        req_t r;
        r.cmd        = cmd;
        r.address    = address;
        r.prefix_len = plen;
        r.route_id   = id;
        return r;
    endfunction

    // Random request. Inserts mostly use legal lengths and often reuse a
    // stored network, so equal and nested prefixes turn up. Lookups mostly
    // aim inside a stored route, mostly with random host bits; the rest are random.
    function automatic req_t random_request();
        req_t              r;
        int                k;
        int                len;
        logic [ADDR_W-1:0] keep;
        r.cmd        = ($urandom_range(99) < 30) ? CMD_INSERT : CMD_LOOKUP;
        r.address    = $urandom;
        r.prefix_len = PLEN_W'($urandom_range(0, 63));
        r.route_id   = ROUTE_W'($urandom_range(0, 255));
        if (r.cmd == CMD_INSERT)
        begin
            if ($urandom_range(99) < 70)
                r.prefix_len = PLEN_W'($urandom_range(0, 32));
            if (route_addr.size() > 0 && $urandom_range(99) < 30)
            begin
                k = $urandom_range(0, route_addr.size() - 1);
                r.address = route_addr[k];
                if ($urandom_range(1) == 1)
                    r.prefix_len = PLEN_W'(route_len[k]);
            end
        end
        else if (route_addr.size() > 0 && $urandom_range(99) < 75)
        begin
            k    = $urandom_range(0, route_addr.size() - 1);
            len  = route_len[k];
            keep = (len == 0) ? '0 : ~({ADDR_W{1'b1}} >> len);
            if ($urandom_range(99) < 20)
                r.address = route_addr[k] & keep;
            else
                r.address = (route_addr[k] & keep) | (r.address & ~keep);
        end
        return r;
    endfunction

    // Offers one request, idling first at the sender's rate, and returns
    // right after the edge that accepts it. Valid stays high between
    // back-to-back requests.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (r.cmd == CMD_INSERT)
        begin
            inserts_sent++;
            if (route_addr.size() < DEPTH)
            begin
                route_addr.push_back(r.address);
                route_len.push_back((r.prefix_len > PLEN_MAX) ? ADDR_W : int'(r.prefix_len));
            end
        end
        else
        begin
            lookups_sent++;
        end
    endtask

    // Stops offering and waits until every response has come back. The
    // outstanding count is read at the falling edge, clear of the checker's
    // update at the rising edge.
    task automatic drain_responses();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run without idling. Lookups on the empty table miss.
        send_request(route_request(CMD_LOOKUP, 32'h0000_0000, 6'd0, 8'h00));
        send_request(route_request(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF));
        // A /8 with host bits set is stored masked.
        send_request(route_request(CMD_INSERT, 32'h0A01_0203, 6'd8, 8'h11));
        send_request(route_request(CMD_LOOKUP, 32'h0AC8_0001, 6'd0, 8'h00));
        send_request(route_request(CMD_LOOKUP, 32'h0B00_0000, 6'd0, 8'h00));
        // A second route with the same prefix must win over the older one.
        send_request(route_request(CMD_INSERT, 32'h0A00_0000, 6'd8, 8'h22));
        send_request(route_request(CMD_LOOKUP, 32'h0A09_0909, 6'd0, 8'h00));
        // A longer prefix inside the /8 wins over both.
        send_request(route_request(CMD_INSERT, 32'h0A01_0000, 6'd16, 8'h33));
        send_request(route_request(CMD_LOOKUP, 32'h0A01_FFFF, 6'd0, 8'h00));
        // Lengths above 32 count as a host route.
        send_request(route_request(CMD_INSERT, 32'hC0A8_0101, 6'd63, 8'hFF));
        send_request(route_request(CMD_LOOKUP, 32'hC0A8_0101, 6'd0, 8'h00));
        send_request(route_request(CMD_LOOKUP, 32'hC0A8_0100, 6'd0, 8'h00));
        send_request(route_request(CMD_INSERT, 32'h0102_0304, 6'd33, 8'h5A));
        send_request(route_request(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h00));
        send_request(route_request(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00));
        send_request(route_request(CMD_LOOKUP, 32'h0102_0304, 6'd0, 8'h00));
        // A zero-length prefix is the default route and catches everything else.
        send_request(route_request(CMD_INSERT, 32'hDEAD_BEEF, 6'd0, 8'hAA));
        send_request(route_request(CMD_LOOKUP, 32'h1234_5678, 6'd0, 8'h00));
        send_request(route_request(CMD_LOOKUP, 32'h0000_0000, 6'd0, 8'h00));
        send_request(route_request(CMD_INSERT, 32'hAC1F_0000, 6'd12, 8'h55));
        send_request(route_request(CMD_INSERT, 32'h8000_0000, 6'd1, 8'h01));
        send_request(route_request(CMD_LOOKUP, 32'h8000_0001, 6'd0, 8'h00));
        drain_responses();

        // Random part in three idling mixes. The remaining table slots fill
        // early in the first mix, after which inserts are refused as full.
        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    rsp_idle_pct <= 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    rsp_idle_pct <= 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_idle_pct <= 0;
                    // Hold responses back while requests keep coming, so the
                    // output register fills and the block stalls its input.
                    hold_asks <= hold_asks + 1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
            drain_responses();
        end

        repeat (DEPTH + 4) @(posedge clk);

        $display("Covered %0d inserts (%0d refused on a full table) and %0d lookups",
                 inserts_sent, refusals, lookups_sent);
        $display("(%0d hits) under three idling mixes and a %0d-cycle response hold-off.",
                 hits, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
